### hdl/page_bitmap_blit_assert.svh
// Assertion macros shared by the blitter modules.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef PAGE_BITMAP_BLIT_ASSERT_SVH
`define PAGE_BITMAP_BLIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pbb_pkg.sv
// Shared types and constants of the page bitmap blitter.
// Used by every module of the block but pbb_ram; depends on nothing.
package pbb_pkg;

  localparam int FRAME_COLUMNS_DEF = 128;
  localparam int FRAME_ROWS_DEF    = 64;

  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = 10;
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEST_X        = 3'd0;
  localparam logic [2:0] REG_DEST_Y        = 3'd1;
  localparam logic [2:0] REG_ANIM_OFFSET   = 3'd2;
  localparam logic [2:0] REG_BITMAP_WIDTH  = 3'd3;
  localparam logic [2:0] REG_BITMAP_HEIGHT = 3'd4;
  localparam logic [2:0] REG_INVERT_PIXELS = 3'd5;
  localparam logic [2:0] REG_OFFSET_UP     = 3'd6;

  // Input item kinds.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_READ,
    OP_BLIT
  } op_t;

  // One store operation handed from the front to the back.
  typedef struct packed {
    op_t                 op;
    logic [STORE_AW-1:0] addr_a;
    logic [7:0]          val_a;
    logic                en_a;
    logic [STORE_AW-1:0] addr_b;
    logic [7:0]          val_b;
    logic                en_b;
  } qentry_t;

endpackage

### hdl/pbb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module pbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/pbb_queue.sv
// Short FIFO of store operations between the front and the back.
// Depends on pbb_pkg for the entry type and depth.
module pbb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pbb_pkg::qentry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output pbb_pkg::qentry_t  head,
  output logic              empty
);

  localparam int PW = $clog2(pbb_pkg::QUEUE_DEPTH);

  pbb_pkg::qentry_t entries [pbb_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(pbb_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/pbb_front.sv
// Front end: configuration registers, bitmap counters and blit geometry.
// Turns accepted items into store operations; depends on pbb_pkg and the assert header.
`include "page_bitmap_blit_assert.svh"

module pbb_front #(
  parameter int FRAME_COLUMNS = pbb_pkg::FRAME_COLUMNS_DEF,
  parameter int FRAME_ROWS    = pbb_pkg::FRAME_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [7:0]                   cfg_data,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   kind,
  input  logic [7:0]                   pixel_byte,
  input  logic [pbb_pkg::STORE_AW-1:0] frame_address,
  input  logic                         clearing,
  output logic                         q_push,
  output pbb_pkg::qentry_t             q_entry,
  input  logic                         q_full
);

  localparam logic [7:0]  COLS_B  = 8'(FRAME_COLUMNS);
  localparam logic [7:0]  ROWS_B  = 8'(FRAME_ROWS);
  localparam logic [13:0] DEPTH_W = 14'(pbb_pkg::STORE_DEPTH);

  logic [7:0] dest_x;
  logic [7:0] dest_y;
  logic [7:0] anim_offset;
  logic [7:0] bitmap_width;
  logic [7:0] bitmap_height;
  logic       invert_pixels;
  logic [7:0] offset_up;

  logic [7:0] base_row;
  logic [7:0] end_row;

  logic [7:0] column_count;
  logic [4:0] page_count;

  // Stage register between acceptance and geometry.
  logic                         f_valid;
  logic [1:0]                   f_kind;
  logic [7:0]                   f_data;
  logic [pbb_pkg::STORE_AW-1:0] f_addr;
  logic                         f_live;
  logic [7:0]                   f_top;
  logic [7:0]                   f_col;

  logic       accept;
  logic       blit_live;
  logic [7:0] top_now;
  logic [7:0] col_inc;
  logic       want_push;
  logic       f_advance;

  logic [7:0]  bot;
  logic [7:0]  d_top;
  logic [7:0]  d_bot;
  logic [7:0]  mask;
  logic        skip_win;
  logic [7:0]  x;
  logic [7:0]  px;
  logic [2:0]  bitofs;
  logic [13:0] wa;
  logic [13:0] wb;
  logic        en_a;
  logic        en_b;
  logic        blit_emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x        <= '0;
      dest_y        <= '0;
      anim_offset   <= '0;
      bitmap_width  <= '0;
      bitmap_height <= '0;
      invert_pixels <= 1'b0;
      offset_up     <= '0;
      base_row      <= '0;
      end_row       <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pbb_pkg::REG_DEST_X:        dest_x        <= cfg_data;
          pbb_pkg::REG_DEST_Y:        dest_y        <= cfg_data;
          pbb_pkg::REG_ANIM_OFFSET:   anim_offset   <= cfg_data;
          pbb_pkg::REG_BITMAP_WIDTH:  bitmap_width  <= cfg_data;
          pbb_pkg::REG_BITMAP_HEIGHT: bitmap_height <= cfg_data;
          pbb_pkg::REG_INVERT_PIXELS: invert_pixels <= cfg_data[0];
          pbb_pkg::REG_OFFSET_UP:     offset_up     <= cfg_data;
          default: ;
        endcase
      end
      // Derived rows are registered, so they follow a register write in the next cycle;
      // they are only read in the geometry stage.
      base_row <= dest_y + anim_offset;
      end_row  <= dest_y + anim_offset + bitmap_height;
    end
  end

  assign blit_live = (kind == pbb_pkg::KIND_PIXEL) && (bitmap_width != 8'd0) &&
                     (page_count < bitmap_height[7:3]);
  assign top_now   = {page_count, 3'b000} + (dest_y + anim_offset - offset_up);
  assign col_inc   = column_count + 8'd1;

  assign f_advance  = !f_valid || !want_push || !q_full;
  assign item_stall = clearing || !f_advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid      <= 1'b0;
      column_count <= '0;
      page_count   <= '0;
    end else begin
      if (accept) begin
        f_valid <= 1'b1;
        if (kind == pbb_pkg::KIND_START) begin
          column_count <= '0;
          page_count   <= '0;
        end else if (blit_live) begin
          if (col_inc >= bitmap_width) begin
            column_count <= '0;
            page_count   <= page_count + 5'd1;
          end else begin
            column_count <= col_inc;
          end
        end
      end else if (f_advance) begin
        f_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_kind <= kind;
      f_data <= pixel_byte;
      f_addr <= frame_address;
      f_live <= blit_live;
      f_top  <= top_now;
      f_col  <= column_count;
    end
  end

  // Geometry of the byte held in the stage register.
  always_comb begin
    bot    = f_top + 8'd8;
    d_top  = base_row - f_top;
    d_bot  = bot - end_row;
    bitofs = f_top[2:0];

    skip_win = (offset_up != 8'd0) &&
               ((bot < base_row) || (bot > ROWS_B) || (f_top > end_row));

    if (offset_up == 8'd0) begin
      mask = 8'hFF;
    end else if (f_top < base_row) begin
      mask = (d_top >= 8'd8) ? 8'h00 : (8'hFF << d_top[2:0]);
    end else if (bot > end_row) begin
      mask = (d_bot >= 8'd8) ? 8'h00 : (8'hFF >> d_bot[2:0]);
    end else begin
      mask = 8'hFF;
    end

    x  = f_col + dest_x;
    px = (f_data ^ {8{invert_pixels}}) & mask;

    wa = 14'(f_top[7:3]) * 14'(FRAME_COLUMNS) + 14'(x);
    wb = 14'(bot[7:3]) * 14'(FRAME_COLUMNS) + 14'(x);

    // A zero bit offset leaves nothing for the lower page.
    en_a = (f_top < ROWS_B) && (wa < DEPTH_W);
    en_b = (bot < ROWS_B) && (bitofs != 3'd0) && (wb < DEPTH_W);

    blit_emit = (f_kind == pbb_pkg::KIND_PIXEL) && f_live && !skip_win &&
                (x < COLS_B) && (en_a || en_b);

    want_push = blit_emit || (f_kind == pbb_pkg::KIND_CLEAR) ||
                (f_kind == pbb_pkg::KIND_READ);

    q_entry.addr_b = wb[pbb_pkg::STORE_AW-1:0];
    q_entry.val_b  = px >> (4'd8 - {1'b0, bitofs});
    q_entry.en_b   = en_b;
    case (f_kind)
      pbb_pkg::KIND_CLEAR: begin
        q_entry.op     = pbb_pkg::OP_CLEAR;
        q_entry.addr_a = f_addr;
        q_entry.val_a  = 8'h00;
        q_entry.en_a   = 1'b1;
      end
      pbb_pkg::KIND_READ: begin
        q_entry.op     = pbb_pkg::OP_READ;
        q_entry.addr_a = f_addr;
        q_entry.val_a  = 8'h00;
        q_entry.en_a   = 1'b1;
      end
      default: begin
        q_entry.op     = pbb_pkg::OP_BLIT;
        q_entry.addr_a = wa[pbb_pkg::STORE_AW-1:0];
        q_entry.val_a  = px << bitofs;
        q_entry.en_a   = en_a;
      end
    endcase
  end

  assign q_push = f_valid && want_push && !q_full;

  `PBB_ASSERT_NEXT(a_start_resets_counters, accept && (kind == pbb_pkg::KIND_START), (column_count == 8'd0) && (page_count == 5'd0), "start transaction did not reset the bitmap counters")
  `PBB_ASSERT_NOW(a_no_accept_while_clearing, clearing, item_stall, "input transaction possible during the store clearing pass")

endmodule

### hdl/pbb_back.sv
// Back end: clears the frame store after reset and executes queued operations.
// Depends on pbb_pkg, pbb_ram and the assert header.
`include "page_bitmap_blit_assert.svh"

module pbb_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  pbb_pkg::qentry_t q_head,
  output logic             q_pop,
  output logic             clearing,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [7:0]       read_data
);

  localparam int AW = pbb_pkg::STORE_AW;

  typedef enum logic [2:0] {
    CLEAR_PASS,
    IDLE,
    RD_WAIT,
    BLIT_A,
    BLIT_B
  } state_t;

  state_t           state;
  state_t           state_next;
  pbb_pkg::qentry_t cur;
  logic [AW-1:0]    clr_addr;
  logic             fwd_hit;
  logic [7:0]       fwd_data;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    rd_eff;
  logic          launch_ok;
  logic          write_busy;
  logic          head_ok;

  pbb_ram #(
    .WIDTH (8),
    .DEPTH (pbb_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // A write in the same cycle as the read of the same byte is forwarded.
  assign rd_eff   = fwd_hit ? fwd_data : ram_rdata;
  assign clearing = (state == CLEAR_PASS);

  always_comb begin
    write_busy = (state == BLIT_A) || (state == BLIT_B);
    launch_ok  = (state == IDLE) || (state == RD_WAIT) || (state == BLIT_B) ||
                 ((state == BLIT_A) && !cur.en_b);
    case (q_head.op)
      pbb_pkg::OP_CLEAR: head_ok = !write_busy;
      pbb_pkg::OP_READ:  head_ok = (state != RD_WAIT) && (!result_valid || !result_stall);
      default:           head_ok = 1'b1;
    endcase
    q_pop = !q_empty && launch_ok && head_ok;

    we    = 1'b0;
    waddr = cur.addr_a;
    wdata = rd_eff | cur.val_a;
    raddr = cur.addr_b;
    case (state)
      CLEAR_PASS: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = 8'h00;
      end
      BLIT_A: begin
        we = 1'b1;
      end
      BLIT_B: begin
        we    = 1'b1;
        waddr = cur.addr_b;
        wdata = rd_eff | cur.val_b;
      end
      default: ;
    endcase

    if (q_pop) begin
      if (q_head.op == pbb_pkg::OP_CLEAR) begin
        we    = 1'b1;
        waddr = q_head.addr_a;
        wdata = 8'h00;
      end else if (q_head.op == pbb_pkg::OP_BLIT && !q_head.en_a) begin
        raddr = q_head.addr_b;
      end else begin
        raddr = q_head.addr_a;
      end
    end

    if (state == CLEAR_PASS) begin
      state_next = (clr_addr == AW'(pbb_pkg::STORE_DEPTH - 1)) ? IDLE : CLEAR_PASS;
    end else if (q_pop) begin
      case (q_head.op)
        pbb_pkg::OP_CLEAR: state_next = IDLE;
        pbb_pkg::OP_READ:  state_next = RD_WAIT;
        default:           state_next = q_head.en_a ? BLIT_A : BLIT_B;
      endcase
    end else if ((state == BLIT_A) && cur.en_b) begin
      state_next = BLIT_B;
    end else begin
      state_next = IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CLEAR_PASS;
      clr_addr     <= '0;
      result_valid <= 1'b0;
      read_data    <= '0;
      fwd_hit      <= 1'b0;
    end else begin
      state   <= state_next;
      fwd_hit <= we && (waddr == raddr);
      if (state == CLEAR_PASS) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == RD_WAIT) begin
        result_valid <= 1'b1;
        read_data    <= rd_eff;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wdata;
    if (q_pop) begin
      cur <= q_head;
    end
  end

  `PBB_ASSERT_NOW(a_no_pop_while_clearing, state == CLEAR_PASS, !q_pop, "queue popped during the clearing pass")
  `PBB_ASSERT_NOW(a_result_slot_free, state == RD_WAIT, !result_valid, "read data arrived while the result register was occupied")
  `PBB_ASSERT_NOW(a_single_writer, q_pop && (q_head.op == pbb_pkg::OP_CLEAR), (state == IDLE) || (state == RD_WAIT), "clear launched while a blit write uses the store")

endmodule

### hdl/page_bitmap_blit.sv
// Page-mode monochrome bitmap blitter, top level.
// Channels: items enter on item_valid/item_stall with kind, pixel_byte and
// frame_address; read results leave on result_valid/result_stall carrying
// read_data. Registers are written on cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write registers only while idle.
// After reset the frame store is cleared one byte per cycle, all 1024 bytes,
// and item_stall stays high throughout; configuration writes are taken.
// The front accepts one item per cycle while item_stall is low, into a
// four-entry operation queue. A read item passes the stage register, the
// queue and RD_WAIT before read_data is registered. Back-end work, set by
// the single write port of the frame store: a bitmap byte touching two store
// bytes is written in BLIT_A then BLIT_B, one touching one byte in either; a
// clear waits out any bitmap write; a read passes RD_WAIT, which a second
// read waits out; start items, clipped and excess bitmap bytes need none.
// When the receiver stalls, the result is held in an output register and
// the queue keeps filling; item_stall rises once the queue and the stage
// in front of it are full.
// Depends on pbb_pkg, pbb_front, pbb_queue and pbb_back.
module page_bitmap_blit #(
  parameter int FRAME_COLUMNS = pbb_pkg::FRAME_COLUMNS_DEF,
  parameter int FRAME_ROWS    = pbb_pkg::FRAME_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [7:0]                   cfg_data,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [1:0]                   kind,
  input  logic [7:0]                   pixel_byte,
  input  logic [pbb_pkg::STORE_AW-1:0] frame_address,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [7:0]                   read_data
);

  logic             clearing;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  pbb_pkg::qentry_t q_entry;
  pbb_pkg::qentry_t q_head;

  pbb_front #(
    .FRAME_COLUMNS (FRAME_COLUMNS),
    .FRAME_ROWS    (FRAME_ROWS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .kind          (kind),
    .pixel_byte    (pixel_byte),
    .frame_address (frame_address),
    .clearing      (clearing),
    .q_push        (q_push),
    .q_entry       (q_entry),
    .q_full        (q_full)
  );

  pbb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  pbb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .read_data    (read_data)
  );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for page_bitmap_blit: drives blits, clears and reads with random
// idling and back-pressure, and checks every read_data against a cycle-free frame predictor.
// Depends on pbb_pkg and the page_bitmap_blit RTL.
module testbench;
  import pbb_pkg::*;

  localparam int COLS          = FRAME_COLUMNS_DEF;
  localparam int ROWS          = FRAME_ROWS_DEF;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEM_TARGET   = 1850;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 100;

  // Writes to this index fall outside the register file and must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // Predicts the frame store contents and queues the byte each read must return.
  class frame_tracker;
    logic [7:0] frame [STORE_DEPTH];
    logic [7:0] pending_reads [$];
    logic [7:0] dest_x, dest_y, anim_offset, bitmap_width, bitmap_height, offset_up;
    logic       invert_pixels;
    logic [7:0] column_count;
    logic [4:0] page_count;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      dest_x = 8'h00;
      dest_y = 8'h00;
      anim_offset = 8'h00;
      bitmap_width = 8'h00;
      bitmap_height = 8'h00;
      offset_up = 8'h00;
      invert_pixels = 1'b0;
      column_count = 8'h00;
      page_count = 5'd0;
    endfunction

    function logic [7:0] shift_left8(logic [7:0] v, logic [7:0] n);
      return (n >= 8) ? 8'h00 : 8'(v << n);
    endfunction

    function logic [7:0] shift_right8(logic [7:0] v, logic [7:0] n);
      return (n >= 8) ? 8'h00 : 8'(v >> n);
    endfunction

    function void or_into(int page, logic [7:0] x, logic [7:0] v);
      int addr;
      addr = int'(x) + page * COLS;
      if (addr < STORE_DEPTH) frame[addr] = frame[addr] | v;
    endfunction

    function void write_reg(logic [2:0] index, logic [7:0] data);
      case (index)
        REG_DEST_X:        dest_x = data;
        REG_DEST_Y:        dest_y = data;
        REG_ANIM_OFFSET:   anim_offset = data;
        REG_BITMAP_WIDTH:  bitmap_width = data;
        REG_BITMAP_HEIGHT: bitmap_height = data;
        REG_INVERT_PIXELS: invert_pixels = data[0];
        REG_OFFSET_UP:     offset_up = data;
        default: ;
      endcase
    endfunction

    // All row arithmetic is 8-bit and wraps, so every step lands in an 8-bit variable.
    function void draw_byte(logic [7:0] data, logic [4:0] page, logic [7:0] col);
      logic [7:0] yy, y, bit_ofs, last_row, top, bot, mask, x, px, diff, rest;
      yy = dest_y + anim_offset;
      y = yy - offset_up;
      bit_ofs = {5'd0, y[2:0]};
      last_row = yy + bitmap_height;
      top = {page, 3'b000} + y;
      bot = top + 8'd8;
      mask = 8'hFF;
      if (offset_up != 8'h00) begin
        if (bot < yy || bot > ROWS || top > last_row) return;
        if (top < yy) begin
          diff = yy - top;
          mask = shift_left8(8'hFF, diff);
        end else if (bot > last_row) begin
          diff = bot - last_row;
          mask = shift_right8(8'hFF, diff);
        end
      end
      x = col + dest_x;
      if (x >= COLS) return;
      px = invert_pixels ? ~data : data;
      px = px & mask;
      rest = 8'd8 - bit_ofs;
      if (bit_ofs == 8'h00 && top < ROWS) begin
        or_into(top >> 3, x, px);
      end else begin
        if (top < ROWS) or_into(top >> 3, x, shift_left8(px, bit_ofs));
        if (bot < ROWS) or_into(bot >> 3, x, shift_right8(px, rest));
      end
    endfunction

    function void accept_item(logic [1:0] k, logic [7:0] data, logic [STORE_AW-1:0] addr);
      case (k)
        KIND_START: begin
          column_count = 8'h00;
          page_count = 5'd0;
        end
        KIND_PIXEL: begin
          if (bitmap_width != 8'h00 && page_count < bitmap_height[7:3]) begin
            draw_byte(data, page_count, column_count);
            column_count = column_count + 8'd1;
            if (column_count >= bitmap_width) begin
              column_count = 8'h00;
              page_count = page_count + 5'd1;
            end
          end
        end
        KIND_CLEAR: frame[addr] = 8'h00;
        default: pending_reads.push_back(frame[addr]);
      endcase
    endfunction

    function bit match_read(logic [7:0] got, output string why);
      logic [7:0] want;
      why = "";
      if (pending_reads.size() == 0) begin
        why = $sformatf("read_data %02h arrived with no read outstanding", got);
        return 1'b0;
      end
      want = pending_reads.pop_front();
      if (got !== want) begin
        why = $sformatf("read_data %02h, predicted %02h", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int reads_outstanding();
      return pending_reads.size();
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = REG_DEST_X;
  logic [7:0]          cfg_data = 8'h00;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [1:0]          kind = KIND_START;
  logic [7:0]          pixel_byte = 8'h00;
  logic [STORE_AW-1:0] frame_address = '0;
  logic                result_valid;
  logic                result_stall;
  logic [7:0]          read_data;
  logic                sink_stall = 1'b0;
  logic                hold_off = 1'b0;

  frame_tracker sb;
  logic [7:0]   cfg_plan [8];
  int           error_count = 0;
  int           cycle_count = 0;
  int           items_sent = 0;
  bit           offering = 1'b0;
  bit           sender_gaps = 1'b1;
  bit           sink_gaps = 1'b1;
  bit           hold_request = 1'b0;

  assign result_stall = sink_stall | hold_off;

  page_bitmap_blit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind(kind),
    .pixel_byte(pixel_byte),
    .frame_address(frame_address),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .read_data(read_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) $display("MISMATCH cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Transactions are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    string why;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (item_valid && !item_stall) sb.accept_item(kind, pixel_byte, frame_address);
      if (result_valid && !result_stall) begin
        if (!sb.match_read(read_data, why)) report_mismatch(why);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: a random hold before each result, with gap-free stretches.
  initial begin : result_sink
    int hold;
    forever begin
      hold = sink_gaps ? $urandom_range(0, 19) : 0;
      if (hold > 0) begin
        sink_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      sink_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  // Long receiver hold-off so the operation queue fills and the input stalls.
  initial begin : long_hold
    forever begin
      wait (hold_request);
      hold_request = 1'b0;
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [7:0] b,
                           input logic [STORE_AW-1:0] a);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      if (offering) item_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    pixel_byte <= b;
    frame_address <= a;
    offering = 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic close_items();
    if (offering) item_valid <= 1'b0;
    offering = 1'b0;
  endtask

  task automatic drain();
    close_items();
    while (sb.reads_outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only once the block has gone idle; the spare index is written each time.
  task automatic apply_settings(input logic [7:0] x, input logic [7:0] y, input logic [7:0] anim,
                                input logic [7:0] w, input logic [7:0] h, input logic [7:0] inv,
                                input logic [7:0] ofs);
    cfg_plan[REG_DEST_X] = x;
    cfg_plan[REG_DEST_Y] = y;
    cfg_plan[REG_ANIM_OFFSET] = anim;
    cfg_plan[REG_BITMAP_WIDTH] = w;
    cfg_plan[REG_BITMAP_HEIGHT] = h;
    cfg_plan[REG_INVERT_PIXELS] = inv;
    cfg_plan[REG_OFFSET_UP] = ofs;
    cfg_plan[REG_UNUSED] = 8'($urandom);
    drain();
    for (int i = 0; i <= REG_UNUSED; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= cfg_plan[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly addresses in the columns the current blit touches, some anywhere.
  function automatic logic [STORE_AW-1:0] near_blit_addr();
    logic [7:0] col;
    if ($urandom_range(0, 3) == 0) return STORE_AW'($urandom);
    col = cfg_plan[REG_DEST_X] + 8'($urandom_range(0, 15));
    return {3'($urandom_range(0, 7)), col[6:0]};
  endfunction

  task automatic random_phase();
    logic [7:0] x, y, anim, w, h, ofs;
    int blit_bytes;
    case ($urandom_range(0, 5))
      0: x = 8'd0;
      1: x = 8'd255;
      2: x = 8'($urandom_range(118, 127));
      3: x = 8'($urandom_range(240, 255));
      default: x = 8'($urandom_range(0, 127));
    endcase
    case ($urandom_range(0, 7))
      0: y = 8'd0;
      1: y = 8'd255;
      2: y = 8'($urandom_range(240, 254));
      3: y = 8'($urandom);
      default: y = 8'($urandom_range(0, 63));
    endcase
    case ($urandom_range(0, 5))
      0: anim = 8'd255;
      1: anim = 8'($urandom_range(1, 15));
      2: anim = 8'($urandom);
      default: anim = 8'd0;
    endcase
    case ($urandom_range(0, 19))
      0: w = 8'd0;
      1: w = 8'd255;
      2: w = 8'($urandom_range(13, 40));
      default: w = 8'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 19))
      0: h = 8'd0;
      1: h = 8'd255;
      2: h = 8'($urandom_range(1, 7));
      default: h = 8'($urandom_range(8, 40));
    endcase
    case ($urandom_range(0, 9))
      0: ofs = 8'd255;
      1, 2, 3, 4: ofs = 8'd0;
      5: ofs = 8'($urandom);
      default: ofs = 8'($urandom_range(1, 12));
    endcase
    apply_settings(x, y, anim, w, h, 8'($urandom), ofs);
    sender_gaps = ($urandom_range(0, 3) != 0);
    sink_gaps = ($urandom_range(0, 3) != 0);

    blit_bytes = int'(w) * int'(h >> 3);
    if (blit_bytes > 64) blit_bytes = $urandom_range(40, 64);
    send_item(KIND_START, 8'($urandom), STORE_AW'($urandom));
    for (int j = 0; j < blit_bytes; j++) begin
      // Occasional interleaved traffic; a stray start breaks the sequence.
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(KIND_READ, 8'($urandom), near_blit_addr());
          1: send_item(KIND_CLEAR, 8'($urandom), near_blit_addr());
          default: send_item(KIND_START, 8'($urandom), STORE_AW'($urandom));
        endcase
      end
      send_item(KIND_PIXEL, 8'($urandom), STORE_AW'($urandom));
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(KIND_PIXEL, 8'($urandom), STORE_AW'($urandom));
    end
    repeat ($urandom_range(12, 24)) begin
      if ($urandom_range(0, 3) == 0) send_item(KIND_CLEAR, 8'($urandom), near_blit_addr());
      else send_item(KIND_READ, 8'($urandom), near_blit_addr());
    end
  endtask

  initial begin : stimulus
    int phase;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero width drops every bitmap byte; reads at both ends of the store.
    send_item(KIND_PIXEL, 8'hA5, '0);
    send_item(KIND_READ, 8'h00, '0);
    send_item(KIND_READ, 8'hFF, '1);

    // Right edge clipping, wrapped vertical offset, inversion, and a byte past the last page.
    apply_settings(8'd126, 8'd3, 8'd255, 8'd4, 8'd16, 8'd1, 8'd0);
    send_item(KIND_START, 8'h00, '0);
    send_item(KIND_PIXEL, 8'h00, '0);
    send_item(KIND_PIXEL, 8'hFF, '0);
    send_item(KIND_PIXEL, 8'h5A, '0);
    send_item(KIND_PIXEL, 8'h81, '0);
    send_item(KIND_PIXEL, 8'h3C, '0);
    send_item(KIND_PIXEL, 8'hC3, '0);
    send_item(KIND_PIXEL, 8'h01, '0);
    send_item(KIND_PIXEL, 8'h80, '0);
    send_item(KIND_PIXEL, 8'hAA, '0);
    send_item(KIND_READ, 8'h00, 10'd126);
    send_item(KIND_READ, 8'h00, 10'd254);
    send_item(KIND_READ, 8'h00, 10'd382);
    send_item(KIND_READ, 8'h00, 10'd127);

    // Upward offset with the window mask at the top of the bitmap.
    apply_settings(8'd10, 8'd20, 8'd0, 8'd1, 8'd24, 8'd0, 8'd5);
    send_item(KIND_START, 8'h00, '0);
    send_item(KIND_PIXEL, 8'hFF, '0);
    send_item(KIND_PIXEL, 8'hFF, '0);
    send_item(KIND_PIXEL, 8'hFF, '0);
    send_item(KIND_READ, 8'h00, 10'd138);
    send_item(KIND_READ, 8'h00, 10'd266);
    send_item(KIND_READ, 8'h00, 10'd394);
    send_item(KIND_CLEAR, 8'h00, 10'd138);
    send_item(KIND_READ, 8'h00, 10'd138);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      random_phase();
      phase++;
      if (phase == 4) begin
        apply_settings(cfg_plan[REG_DEST_X], cfg_plan[REG_DEST_Y], cfg_plan[REG_ANIM_OFFSET],
                       cfg_plan[REG_BITMAP_WIDTH], cfg_plan[REG_BITMAP_HEIGHT],
                       cfg_plan[REG_INVERT_PIXELS], cfg_plan[REG_OFFSET_UP]);
        sender_gaps = 1'b0;
        hold_request = 1'b1;
        repeat (40) send_item(KIND_READ, 8'($urandom), near_blit_addr());
      end
    end

    drain();
    if (sb.reads_outstanding() != 0) report_mismatch("reads still outstanding at the end");
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

### filelist.f
+incdir+hdl
hdl/pbb_pkg.sv
hdl/pbb_ram.sv
hdl/pbb_queue.sv
hdl/pbb_front.sv
hdl/pbb_back.sv
hdl/page_bitmap_blit.sv
tb/sv/testbench.sv
